### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

### sv/ptpct_pkg.sv
// Shared types, constants and helpers for the container tracker.
`default_nettype none

package ptpct_pkg;

  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgIdxW-1:0] CfgTransIdOffset = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBypass        = 1'd1;

  localparam logic [31:0] HdrLen       = 32'd12;
  localparam logic [3:0]  IdFirst      = 4'd8;
  localparam logic [3:0]  HdrLast      = 4'd11;
  localparam logic [15:0] TypeData     = 16'd2;
  localparam logic [15:0] TypeResponse = 16'd3;

  // Phase codes as reported on the result.
  localparam logic [2:0] PhCodeReady   = 3'd0;
  localparam logic [2:0] PhCodeWait    = 3'd1;
  localparam logic [2:0] PhCodeHeader  = 3'd2;
  localparam logic [2:0] PhCodeData    = 3'd3;
  localparam logic [2:0] PhCodeResp    = 3'd4;
  localparam logic [2:0] PhCodeUnknown = 3'd5;

  typedef enum logic [5:0] {
    PhReady   = 6'b000001,
    PhWait    = 6'b000010,
    PhHeader  = 6'b000100,
    PhData    = 6'b001000,
    PhResp    = 6'b010000,
    PhUnknown = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] phase;
    logic       container_end;
    logic       response_done;
  } result_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PhWait:    code = PhCodeWait;
      PhHeader:  code = PhCodeHeader;
      PhData:    code = PhCodeData;
      PhResp:    code = PhCodeResp;
      PhUnknown: code = PhCodeUnknown;
      default:   code = PhCodeReady;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### sv/ptpct_tracker.sv
// Container framing state, id rewrite and configuration registers.
`default_nettype none

module ptpct_tracker import ptpct_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                step_i,
  input  wire logic [7:0]          data_byte_i,
  output result_t                  res_o
);

  logic [31:0] offset_q;
  logic        bypass_q;

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [15:0] typ_q, typ_d;
  logic        bor_q, bor_d;

  logic        start;
  logic [3:0]  idx;
  logic [7:0]  ob;
  logic [7:0]  ofs;
  logic [8:0]  diff;
  logic        fin;
  logic        resp;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    typ_d   = typ_q;
    bor_d   = bor_q;
    ob      = data_byte_i;
    ofs     = 8'd0;
    diff    = 9'd0;
    fin     = 1'b0;
    resp    = 1'b0;
    start   = !(phase_q inside {PhHeader, PhData, PhResp, PhUnknown});
    // Open a new header on any byte while no container is open (after reset or a finished container).
    if (start) begin
      phase_d = PhHeader;
      cnt_d   = 32'd0;
      len_d   = 32'd0;
      typ_d   = 16'd0;
      bor_d   = 1'b0;
    end
    idx = cnt_d[3:0];
    if (phase_d == PhHeader) begin
      if (idx < 4'd4) begin
        len_d[{idx[1:0], 3'b000} +: 8] = data_byte_i;
      end else if (idx < 4'd6) begin
        typ_d[{idx[0], 3'b000} +: 8] = data_byte_i;
      end else if (idx >= IdFirst) begin
        // Subtract one offset byte plus the carried borrow.
        ofs   = offset_q[{idx[1:0], 3'b000} +: 8];
        diff  = {1'b0, data_byte_i} - ({1'b0, ofs} + {8'd0, bor_d});
        ob    = diff[7:0];
        bor_d = diff[8];
      end
      cnt_d = cnt_d + 32'd1;
      if (idx == HdrLast) begin
        cnt_d = HdrLen;
        if (typ_d == TypeResponse) begin
          phase_d = PhResp;
        end else if (typ_d == TypeData) begin
          phase_d = PhData;
        end else begin
          phase_d = PhUnknown;
        end
        fin = (len_d <= HdrLen);
      end
    end else begin
      // Count payload bytes, saturating at the top.
      if (cnt_d != 32'hffff_ffff) begin
        cnt_d = cnt_d + 32'd1;
      end
      fin = (cnt_d >= len_d);
    end
    if (fin) begin
      if (phase_d == PhResp) begin
        phase_d = PhReady;
        resp    = 1'b1;
      end else begin
        phase_d = PhWait;
      end
    end
  end

  always_comb begin
    if (bypass_q) begin
      res_o.out_byte      = data_byte_i;
      res_o.phase         = phase_code(phase_q);
      res_o.container_end = 1'b0;
      res_o.response_done = 1'b0;
    end else begin
      res_o.out_byte      = ob;
      res_o.phase         = phase_code(phase_d);
      res_o.container_end = fin;
      res_o.response_done = resp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 32'd0;
      bypass_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgTransIdOffset) begin
        offset_q <= cfg_data_i;
      end else if (cfg_idx_i == CfgBypass) begin
        bypass_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhReady;
      cnt_q   <= 32'd0;
      len_q   <= 32'd0;
      typ_q   <= 16'd0;
      bor_q   <= 1'b0;
    end else if (step_i && !bypass_q) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      typ_q   <= typ_d;
      bor_q   <= bor_d;
    end
  end

endmodule

`default_nettype wire

### sv/ptpct_out_buf.sv
// Result register with a skid stage so input and output stall independently.
`default_nettype none

module ptpct_out_buf import ptpct_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  result_t   data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output result_t   data_o
);

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q;
  result_t skid_q;
  logic    take;

  assign ready_o = !skid_v_q;
  assign take    = valid_i && ready_o;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

  always_comb begin
    if (skid_v_q) begin
      out_v_d  = 1'b1;
      skid_v_d = !ready_i;
    end else begin
      out_v_d  = take || (out_v_q && !ready_i);
      skid_v_d = take && out_v_q && !ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q && ready_i) begin
      out_q <= skid_q;
    end else if (take && (!out_v_q || ready_i)) begin
      out_q <= data_i;
    end
    // Park the request when the result register is still held.
    if (take && out_v_q && !ready_i) begin
      skid_q <= data_i;
    end
  end

endmodule

`default_nettype wire

### sv/ptp_container_tracker_id_rewriter.sv
// A result is registered at the output when its byte is accepted, via the skid register if the output is held.
// Throughput: one byte per cycle while input is ready; the framing and id-borrow update is combinational.
// A two-entry result buffer keeps input ready while one result waits to be taken.
// Reset: phase ready, counters cleared, offset 0, bypass off, result buffer empty.
`default_nettype none
`include "assert_macros.svh"

module ptp_container_tracker_id_rewriter import ptpct_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          data_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic [2:0]               phase_o,
  output logic                     container_end_o,
  output logic                     response_done_o
);

  result_t res;
  result_t out_res;
  logic    step;

  assign step = in_valid_i && in_ready_o;

  ptpct_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .data_byte_i (data_byte_i),
    .res_o       (res)
  );

  ptpct_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign out_byte_o      = out_res.out_byte;
  assign phase_o         = out_res.phase;
  assign container_end_o = out_res.container_end;
  assign response_done_o = out_res.response_done;

  `ASSERT_PROP(a_resp_ends, clk_i, rst_ni, out_valid_o && response_done_o |-> container_end_o)
  `ASSERT_PROP(a_resp_ready, clk_i, rst_ni,
               out_valid_o && response_done_o |-> phase_o == PhCodeReady)
  `ASSERT_NEVER(a_stall_pending, clk_i, rst_ni, !in_ready_o && !out_valid_o)

endmodule

`default_nettype wire

### bench/tb_ptp_container_tracker_id_rewriter.sv
// Testbench for the PTP container tracker: random container streams checked by a scoreboard.
`timescale 1ns / 1ps

module tb_ptp_container_tracker_id_rewriter;
  import ptpct_pkg::*;

  localparam int StallLimit = 4000;

  // Tracks container framing and id rewriting, queues the result each request must produce.
  class id_rewrite_scoreboard;
    bit [31:0] offset;
    bit        bypass_on;
    bit [2:0]  ph_code;
    bit [31:0] count;
    bit [31:0] length;
    bit [15:0] ctype;
    bit        borrow;
    result_t   pending[$];
    int        errors;
    int        containers;
    int        responses;
    int        bypass_bytes;

    function void apply_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgTransIdOffset) begin
        offset = data;
      end else if (idx == CfgBypass) begin
        bypass_on = data[0];
      end
    endfunction

    function void close_container(inout result_t r);
      r.container_end = 1'b1;
      if (ph_code == PhCodeResp) begin
        r.response_done = 1'b1;
        ph_code = PhCodeReady;
      end else begin
        ph_code = PhCodeWait;
      end
    endfunction

    function void note_request(bit [7:0] b);
      result_t   want;
      bit [3:0]  idx;
      bit [7:0]  ofs_byte;
      bit [8:0]  sub;
      want = '{out_byte: b, phase: ph_code, container_end: 1'b0, response_done: 1'b0};
      if (bypass_on) begin
        bypass_bytes++;
        pending.push_back(want);
        return;
      end
      // A byte seen between containers opens a new header.
      if (ph_code == PhCodeReady || ph_code == PhCodeWait || ph_code > PhCodeUnknown) begin
        ph_code = PhCodeHeader;
        count = '0;
        length = '0;
        ctype = '0;
        borrow = 1'b0;
      end
      if (ph_code == PhCodeHeader) begin
        idx = count[3:0];
        if (idx < 4) begin
          length |= 32'(b) << (8 * idx);
        end else if (idx < 6) begin
          ctype |= 16'(b) << (8 * (idx - 4));
        end else if (idx >= IdFirst && idx <= HdrLast) begin
          // Subtract the offset one byte at a time, least significant first.
          ofs_byte = offset[8 * (idx - IdFirst) +: 8];
          sub = {1'b0, ofs_byte} + 9'(borrow);
          want.out_byte = b - sub[7:0];
          borrow = ({1'b0, b} < sub);
        end
        count++;
        if (count >= HdrLen) begin
          count = HdrLen;
          if (ctype == TypeResponse) begin
            ph_code = PhCodeResp;
          end else if (ctype == TypeData) begin
            ph_code = PhCodeData;
          end else begin
            ph_code = PhCodeUnknown;
          end
          // Short declared length ends the container at the header.
          if (length <= HdrLen) close_container(want);
        end
      end else begin
        if (count != 32'hFFFF_FFFF) count++;
        if (count >= length) close_container(want);
      end
      want.phase = ph_code;
      pending.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result with no request waiting: out_byte %0h", got.out_byte);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, actual %0d", want.phase, got.phase);
        errors++;
      end
      if (got.container_end !== want.container_end) begin
        $error("container_end: expected %0b, actual %0b", want.container_end,
               got.container_end);
        errors++;
      end
      if (got.response_done !== want.response_done) begin
        $error("response_done: expected %0b, actual %0b", want.response_done,
               got.response_done);
        errors++;
      end
      if (want.container_end) containers++;
      if (want.response_done) responses++;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic [2:0]          phase_o;
  logic                container_end_o;
  logic                response_done_o;

  id_rewrite_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int bytes_sent = 0;

  ptp_container_tracker_id_rewriter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .phase_o        (phase_o),
    .container_end_o(container_end_o),
    .response_done_o(response_done_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Observe both handshakes; the watchdog counts cycles with neither.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(data_byte_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result({out_byte_o, phase_o, container_end_o, response_done_o});
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("ptp_container_tracker_id_rewriter: mismatch");
          $finish;
        end
      end
    end
  end

  task automatic write_regs(input logic [31:0] ofs, input logic bp);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgTransIdOffset;
    cfg_data_i <= ofs;
    @(posedge clk_i);
    sb.apply_config(CfgTransIdOffset, ofs);
    cfg_idx_i <= CfgBypass;
    cfg_data_i <= {31'd0, bp};
    @(posedge clk_i);
    sb.apply_config(CfgBypass, {31'd0, bp});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] b);
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic push_container(input logic [31:0] len, input logic [15:0] ctype,
                                input logic [15:0] code, input logic [31:0] tid,
                                input int payload);
    logic [95:0] hdr;
    hdr = {tid, code, ctype, len};
    for (int i = 0; i < 12; i++) push_byte(hdr[8 * i +: 8]);
    repeat (payload) push_byte(8'($urandom_range(255)));
  endtask

  task automatic random_container();
    logic [31:0] len;
    logic [15:0] ctype;
    logic [31:0] tid;
    int          sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      ctype = TypeData;
    end else if (sel < 75) begin
      ctype = TypeResponse;
    end else begin
      case ($urandom_range(4))
        0:       ctype = 16'h0000;
        1:       ctype = 16'h0001;
        2:       ctype = 16'h0004;
        3:       ctype = 16'hFFFF;
        default: ctype = 16'($urandom);
      endcase
    end
    sel = $urandom_range(99);
    if (sel < 80) begin
      len = HdrLen + $urandom_range(24);
    end else if (sel < 97) begin
      len = $urandom_range(12);
    end else begin
      len = HdrLen + $urandom_range(256, 300);
    end
    sel = $urandom_range(9);
    tid = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
    push_container(len, ctype, 16'($urandom), tid, (len > HdrLen) ? int'(len - HdrLen) : 0);
  endtask

  task automatic random_stream(input int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) random_container();
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    // Let the last accepted request land in the scoreboard before polling.
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Borrow through all four id bytes, then a one-byte data container.
    write_regs(32'hFFFF_FFFF, 1'b0);
    push_container(32'd5, TypeResponse, 16'h00FF, 32'h0000_0000, 0);
    push_container(32'd13, TypeData, 16'hFFFF, 32'hFFFF_FFFF, 1);
    wait_drained();

    tx_idle_pct = 28;
    rx_idle_pct = 78;
    write_regs(32'h0, 1'b0);
    random_stream(150);
    wait_drained();

    tx_idle_pct = 78;
    rx_idle_pct = 28;
    write_regs($urandom, 1'b1);
    repeat (60) push_byte(8'($urandom_range(255)));
    wait_drained();
    write_regs($urandom, 1'b0);
    random_stream(150);
    wait_drained();

    // Long receiver hold-off with a busy sender fills the block.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_regs(32'hFFFF_FFFF, 1'b0);
    hold_left = 240;
    random_stream(80);
    wait_drained();
    random_stream(80);
    wait_drained();

    // A container that never ends: its declared length is all ones, so the data phase stays open.
    push_container(32'hFFFF_FFFF, TypeData, 16'($urandom), $urandom, 30);
    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Sent %0d bytes in %0d completed containers (%0d responses), %0d in bypass.",
             bytes_sent, sb.containers, sb.responses, sb.bypass_bytes);
    $display("Offsets zero, all-ones and random; output hold-off and input stall exercised.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ptp_container_tracker_id_rewriter: match");
    end else begin
      $display("ptp_container_tracker_id_rewriter: mismatch");
    end
    $finish;
  end

endmodule
